// File: sv/address_range_overlap_table_defines.svh
// Assertion macros shared by the address range overlap table RTL.
`ifndef ADDRESS_RANGE_OVERLAP_TABLE_DEFINES_SVH
`define ADDRESS_RANGE_OVERLAP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AROT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("address range table check failed");

// Next-cycle implication, disabled during reset.
`define AROT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("address range table check failed");

`endif

// File: sv/arot_pkg.sv
// Types, codes and constants of the address range overlap table.
package arot_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int ADDR_W          = 32;
   localparam int IDX_W           = 6;
   localparam int STATUS_W        = 3;
   localparam int KEY_W           = ADDR_W + IDX_W;

   // Operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_DUMP = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY_RANGE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERLAP     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TABLE_EMPTY = 3'd4;

   typedef struct packed {
      logic              operation;
      logic [ADDR_W-1:0] range_begin;
      logic [ADDR_W-1:0] range_end;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    entry_index;
      logic [ADDR_W-1:0]   entry_begin;
      logic [ADDR_W-1:0]   entry_end;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] begin_addr;
      logic [ADDR_W-1:0] end_addr;
   } entry_type;

   // Operands of the shared compare unit: two less-than tests.
   typedef struct packed {
      logic [KEY_W-1:0] a0;
      logic [KEY_W-1:0] b0;
      logic [KEY_W-1:0] a1;
      logic [KEY_W-1:0] b1;
   } cmp_req_type;

   typedef struct packed {
      logic lt0;
      logic lt1;
   } cmp_rsp_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_WRITE,
      SEQ_PICK,
      SEQ_EMIT
   } seq_state_type;

endpackage

// File: sv/arot_cmp.sv
// Shared compare unit: two unsigned less-than tests on sort keys.
module arot_cmp
   import arot_pkg::*;
(
   input  cmp_req_type cmp_req,
   output cmp_rsp_type cmp_rsp
);

   // Compare both operand pairs
   always_comb begin
      cmp_rsp.lt0 = cmp_req.a0 < cmp_req.b0;
      cmp_rsp.lt1 = cmp_req.a1 < cmp_req.b1;
   end

endmodule

// File: sv/arot_mem.sv
// Range store: one write port and one registered read port.
module arot_mem
   import arot_pkg::*;
#(
   parameter  int DEPTH = MAX_ENTRIES_DEF,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write the new range
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/arot_ctrl.sv
// Sequencer of the range table: scans for overlap, appends, and sorts for dump.
module arot_ctrl
   import arot_pkg::*;
#(
   parameter  int MAX_ENTRIES = MAX_ENTRIES_DEF,
   localparam int IW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CW          = $clog2(MAX_ENTRIES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   output logic          mem_wr_en,
   output logic [IW-1:0] mem_wr_addr,
   output entry_type     mem_wr_data,
   output logic          mem_rd_en,
   output logic [IW-1:0] mem_rd_addr,
   input  entry_type     mem_rd_data
);

   seq_state_type     state_ff, state_in;
   logic              op_ff, op_in;
   logic [ADDR_W-1:0] nb_ff, nb_in;
   logic [ADDR_W-1:0] ne_ff, ne_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     addr_ff, addr_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic              found_ff, found_in;
   logic [KEY_W-1:0]  best_key_ff, best_key_in;
   logic [ADDR_W-1:0] best_end_ff, best_end_in;
   logic [KEY_W-1:0]  prev_key_ff, prev_key_in;
   logic              have_prev_ff, have_prev_in;
   logic [CW-1:0]     pass_ff, pass_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              req_fire;
   logic              slot_free;
   logic [CW-1:0]     last_cnt;
   logic              scan_last;
   logic              issue;
   logic [KEY_W-1:0]  rd_key;
   logic              overlap_hit;
   logic              better;
   logic              in_empty;
   logic              tbl_full;
   cmp_req_type       cmp_req;
   cmp_rsp_type       cmp_rsp;

   // Handshake and scan status
   assign req_ready   = (state_ff == SEQ_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign last_cnt    = count_ff - CW'(1);
   assign scan_last   = (rd_idx_ff == last_cnt[IW-1:0]);
   assign issue       = (state_ff == SEQ_SCAN) && (addr_ff < count_ff);
   assign rd_key      = {mem_rd_data.begin_addr, IDX_W'(rd_idx_ff)};
   assign in_empty    = (req_data.range_begin == req_data.range_end);
   assign tbl_full    = (count_ff == CW'(MAX_ENTRIES));

   // Route operands to the shared compare unit
   always_comb begin
      if (op_ff == OP_ADD) begin
         cmp_req.a0 = {mem_rd_data.begin_addr, IDX_W'(0)};
         cmp_req.b0 = {ne_ff, IDX_W'(0)};
         cmp_req.a1 = {nb_ff, IDX_W'(0)};
         cmp_req.b1 = {mem_rd_data.end_addr, IDX_W'(0)};
      end else begin
         cmp_req.a0 = prev_key_ff;
         cmp_req.b0 = rd_key;
         cmp_req.a1 = rd_key;
         cmp_req.b1 = best_key_ff;
      end
   end

   arot_cmp u_cmp (
      .cmp_req (cmp_req),
      .cmp_rsp (cmp_rsp)
   );

   assign overlap_hit = rd_valid_ff && cmp_rsp.lt0 && cmp_rsp.lt1;
   assign better      = (!have_prev_ff || cmp_rsp.lt0) && (!found_ff || cmp_rsp.lt1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               if (req_data.operation == OP_DUMP) begin
                  state_in = (count_ff == '0) ? SEQ_EMIT : SEQ_SCAN;
               end else if (in_empty || tbl_full) begin
                  state_in = SEQ_EMIT;
               end else if (count_ff == '0) begin
                  state_in = SEQ_WRITE;
               end else begin
                  state_in = SEQ_SCAN;
               end
            end
         end
         SEQ_SCAN: begin
            if (rd_valid_ff) begin
               if (op_ff == OP_ADD) begin
                  if (overlap_hit) begin
                     state_in = SEQ_EMIT;
                  end else if (scan_last) begin
                     state_in = SEQ_WRITE;
                  end
               end else if (scan_last) begin
                  state_in = SEQ_PICK;
               end
            end
         end
         SEQ_WRITE: begin
            state_in = SEQ_EMIT;
         end
         SEQ_PICK: begin
            state_in = SEQ_EMIT;
         end
         SEQ_EMIT: begin
            if (slot_free) begin
               state_in = res_ff.last ? SEQ_IDLE : SEQ_SCAN;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      op_in        = op_ff;
      nb_in        = nb_ff;
      ne_in        = ne_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      rd_valid_in  = rd_valid_ff;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      best_key_in  = best_key_ff;
      best_end_in  = best_end_ff;
      prev_key_in  = prev_key_ff;
      have_prev_in = have_prev_ff;
      pass_in      = pass_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = count_ff[IW-1:0];
      mem_wr_data  = '{begin_addr: nb_ff, end_addr: ne_ff};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = addr_ff[IW-1:0];
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               op_in        = req_data.operation;
               nb_in        = req_data.range_begin;
               ne_in        = req_data.range_end;
               addr_in      = '0;
               rd_valid_in  = 1'b0;
               found_in     = 1'b0;
               have_prev_in = 1'b0;
               pass_in      = '0;
               if (req_data.operation == OP_DUMP) begin
                  res_in = '{status: ST_TABLE_EMPTY, entry_index: '0,
                             entry_begin: '0, entry_end: '0, last: 1'b1};
               end else begin
                  res_in = '{status: in_empty ? ST_EMPTY_RANGE : ST_FULL,
                             entry_index: '0, entry_begin: req_data.range_begin,
                             entry_end: req_data.range_end, last: 1'b1};
               end
            end
         end
         SEQ_SCAN: begin
            // Issue the next read while the previous word is compared
            mem_rd_en   = issue;
            rd_valid_in = issue;
            rd_idx_in   = addr_ff[IW-1:0];
            if (issue) begin
               addr_in = addr_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               if (op_ff == OP_ADD) begin
                  if (overlap_hit) begin
                     rd_valid_in = 1'b0;
                     res_in = '{status: ST_OVERLAP, entry_index: IDX_W'(rd_idx_ff),
                                entry_begin: mem_rd_data.begin_addr,
                                entry_end: mem_rd_data.end_addr, last: 1'b1};
                  end
               end else if (better) begin
                  found_in    = 1'b1;
                  best_key_in = rd_key;
                  best_end_in = mem_rd_data.end_addr;
               end
            end
         end
         SEQ_WRITE: begin
            // Append the range at the fill count
            mem_wr_en = 1'b1;
            count_in  = count_ff + CW'(1);
            res_in    = '{status: ST_OK, entry_index: IDX_W'(count_ff[IW-1:0]),
                          entry_begin: nb_ff, entry_end: ne_ff, last: 1'b1};
         end
         SEQ_PICK: begin
            // Report the smallest key above the previous one
            prev_key_in  = best_key_ff;
            have_prev_in = 1'b1;
            pass_in      = pass_ff + CW'(1);
            res_in       = '{status: ST_OK, entry_index: best_key_ff[IDX_W-1:0],
                             entry_begin: best_key_ff[KEY_W-1:IDX_W],
                             entry_end: best_end_ff, last: (pass_ff == last_cnt)};
         end
         SEQ_EMIT: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               addr_in      = '0;
               rd_valid_in  = 1'b0;
               found_in     = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         have_prev_ff <= have_prev_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      nb_ff       <= nb_in;
      ne_ff       <= ne_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      best_key_ff <= best_key_in;
      best_end_ff <= best_end_in;
      prev_key_ff <= prev_key_in;
      pass_ff     <= pass_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/address_range_overlap_table.sv
// Top level of the address range overlap table.
// Empty, full and empty-dump items: the result goes to the result register and then
// to the output register, with no table scan. Add with n stored ranges: one entry
// read per cycle from the single read port of the range memory. Dump: one full
// scan of the table per reported range.
// Reset clears the fill count and all control state; the memory is not cleared.
module address_range_overlap_table
   import arot_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "address_range_overlap_table_defines.svh"

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   entry_type     mem_wr_data;
   logic          mem_rd_en;
   logic [IW-1:0] mem_rd_addr;
   entry_type     mem_rd_data;

   arot_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   arot_mem #(
      .DEPTH (MAX_ENTRIES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Appends and scans never share a cycle
   `AROT_ASSERT_NOW(a_no_rd_wr, clock, reset, mem_wr_en, !mem_rd_en)
   // An accepted beat always leaves the block busy in the next cycle
   `AROT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // An append is followed by its result stage, not by a new beat
   `AROT_ASSERT_NEXT(a_busy_after_wr, clock, reset, mem_wr_en, !req_ready)
   // Table reads happen only while an item is in progress
   `AROT_ASSERT_NOW(a_rd_busy, clock, reset, mem_rd_en, !req_ready)

endmodule

// File: tb/tb.sv
// Self-checking testbench for the address range overlap table.
module tb
   import arot_pkg::*;
();

   localparam int TABLE_DEPTH    = MAX_ENTRIES_DEF;
   localparam int RESET_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int IDLE_PERCENT   = 8;
   localparam int QUIET_FROM     = 120;
   localparam int QUIET_UPTO     = 220;
   localparam int MIXED_ITEMS    = 400;
   localparam int SATURATED_ITEMS = 40;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Pending request beats, expected result beats, and the table as predicted
   req_type     pending_req[$];
   rsp_type     awaited_rsp[$];
   logic [31:0] held_begin[TABLE_DEPTH];
   logic [31:0] held_end[TABLE_DEPTH];
   int          held_count  = 0;
   int          sent_beats  = 0;
   int          fail_count  = 0;
   int          quiet_cycles = 0;
   logic        calm;

   address_range_overlap_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stretch of beats with no idling on either side
   assign calm = (sent_beats >= QUIET_FROM) && (sent_beats < QUIET_UPTO);

   // Half-open ranges meet when each starts below the other's end
   function automatic bit ranges_meet(logic [31:0] sb, logic [31:0] se,
                                      logic [31:0] nb, logic [31:0] ne);
      return (sb < ne) && (se > nb);
   endfunction

   // Lowest held entry that a new range runs into, or -1
   function automatic int first_clash(logic [31:0] nb, logic [31:0] ne);
      for (int i = 0; i < held_count; i++) begin
         if (ranges_meet(held_begin[i], held_end[i], nb, ne)) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Update the predicted table and queue the result beats of one request
   function automatic void predict_results(req_type item);
      rsp_type r;
      int      clash;
      int      rank;
      int      order[TABLE_DEPTH];
      r      = '0;
      r.last = 1'b1;
      if (item.operation == OP_ADD) begin
         r.entry_begin = item.range_begin;
         r.entry_end   = item.range_end;
         if (item.range_begin == item.range_end) begin
            r.status = ST_EMPTY_RANGE;
         end else if (held_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            clash = first_clash(item.range_begin, item.range_end);
            if (clash >= 0) begin
               r.status      = ST_OVERLAP;
               r.entry_index = clash[IDX_W-1:0];
               r.entry_begin = held_begin[clash];
               r.entry_end   = held_end[clash];
            end else begin
               held_begin[held_count] = item.range_begin;
               held_end[held_count]   = item.range_end;
               r.status      = ST_OK;
               r.entry_index = held_count[IDX_W-1:0];
               held_count++;
            end
         end
         awaited_rsp.push_back(r);
      end else if (held_count == 0) begin
         r.status = ST_TABLE_EMPTY;
         awaited_rsp.push_back(r);
      end else begin
         // Rank by begin, ties to the lower index
         for (int i = 0; i < held_count; i++) begin
            rank = 0;
            for (int j = 0; j < held_count; j++) begin
               if (held_begin[j] < held_begin[i] ||
                   (held_begin[j] == held_begin[i] && j < i)) begin
                  rank++;
               end
            end
            order[rank] = i;
         end
         for (int k = 0; k < held_count; k++) begin
            r.status      = ST_OK;
            r.entry_index = order[k][IDX_W-1:0];
            r.entry_begin = held_begin[order[k]];
            r.entry_end   = held_end[order[k]];
            r.last        = (k == held_count - 1);
            awaited_rsp.push_back(r);
         end
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s expected 0x%0h actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Driver: present the next pending beat, hold it until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_req.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_data  <= pending_req.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on request beats, check result beats, throttle ready
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_results(req_data);
            sent_beats <= sent_beats + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("unexpected result beat status %0d index %0d",
                      rsp_data.status, rsp_data.entry_index);
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("entry_index", 32'(want.entry_index),
                           32'(rsp_data.entry_index));
               check_field("entry_begin", want.entry_begin, rsp_data.entry_begin);
               check_field("entry_end", want.entry_end, rsp_data.entry_end);
               check_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: end the run after too long without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("address_range_overlap_table verification failed");
            $finish;
         end
      end
   end

   function automatic void push_req(logic op, logic [31:0] lo, logic [31:0] hi);
      req_type item;
      item.operation   = op;
      item.range_begin = lo;
      item.range_end   = hi;
      pending_req.push_back(item);
   endfunction

   // Hold until every queued beat is sent and every result has come back
   task automatic wait_drained();
      while (pending_req.size() != 0 || req_valid || awaited_rsp.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int          roll;
      int          tries;
      bit          free;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] win_base;
      entry_type   spot;
      entry_type   picked[$];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty dump, empty ranges at the extremes, adjacency,
      // overlap, inverted ranges with equal begins, then dumps
      push_req(OP_DUMP, 32'h0, 32'h0);
      push_req(OP_ADD, 32'h0, 32'h0);
      push_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(OP_ADD, 32'h0, 32'h10);
      push_req(OP_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      push_req(OP_ADD, 32'h8, 32'h20);
      push_req(OP_ADD, 32'h10, 32'h20);
      push_req(OP_ADD, 32'hFFFF_FF00, 32'hFFFF_FFF0);
      push_req(OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      push_req(OP_ADD, 32'h100, 32'h200);
      push_req(OP_ADD, 32'h100, 32'h50);
      push_req(OP_ADD, 32'h100, 32'h0);
      push_req(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
      push_req(OP_ADD, 32'h0, 32'hFFFF_FFFF);
      push_req(OP_ADD, 32'hFFFF_FFFF, 32'h1);
      push_req(OP_ADD, 32'h1F0, 32'h210);
      push_req(OP_DUMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(OP_ADD, 32'h200, 32'h210);
      push_req(OP_DUMP, $urandom, $urandom);
      wait_drained();

      // Mixed traffic: mostly small ranges in a crowded window
      win_base = $urandom & 32'hFFFF_0000;
      for (int n = 0; n < MIXED_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         lo   = $urandom;
         hi   = $urandom;
         if (roll < 8) begin
            push_req(OP_DUMP, lo, hi);
         end else if (roll < 16) begin
            push_req(OP_ADD, lo, lo);
         end else if (roll < 24) begin
            // Wide ranges, mostly inverted so the window stays usable
            if (hi > lo && $urandom_range(0, 7) != 0) begin
               push_req(OP_ADD, hi, lo);
            end else begin
               push_req(OP_ADD, lo, hi);
            end
         end else begin
            lo = win_base + $urandom_range(0, 'h5FF);
            if ($urandom_range(0, 9) == 0) begin
               push_req(OP_ADD, lo, lo - $urandom_range(1, 48));
            end else begin
               push_req(OP_ADD, lo, lo + $urandom_range(1, 48));
            end
         end
      end
      wait_drained();

      // Fill the table with ranges known to be free
      tries = 0;
      while (held_count + picked.size() < TABLE_DEPTH && tries < 5000) begin
         tries++;
         lo   = $urandom;
         hi   = lo + $urandom_range(1, 16);
         free = (hi > lo) && (first_clash(lo, hi) < 0);
         foreach (picked[i]) begin
            if (ranges_meet(picked[i].begin_addr, picked[i].end_addr, lo, hi)) begin
               free = 1'b0;
            end
         end
         if (free) begin
            spot.begin_addr = lo;
            spot.end_addr   = hi;
            picked.push_back(spot);
            push_req(OP_ADD, lo, hi);
            if (picked.size() % 16 == 0) begin
               push_req(OP_DUMP, $urandom, $urandom);
            end
         end
      end
      push_req(OP_DUMP, $urandom, $urandom);

      // Full table: refused adds, empty ranges, full dumps
      for (int n = 0; n < SATURATED_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         lo   = $urandom;
         hi   = $urandom;
         if (roll < 15) begin
            push_req(OP_DUMP, lo, hi);
         end else if (roll < 35) begin
            push_req(OP_ADD, lo, lo);
         end else begin
            push_req(OP_ADD, lo, hi);
         end
      end
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && awaited_rsp.size() == 0) begin
         $display("address_range_overlap_table verification clean");
      end else begin
         $display("address_range_overlap_table verification failed");
      end
      $finish;
   end

endmodule
